/* src/brfb_pkg.sv */
// Shared constants, mode codes and word types for the byte ring FIFO.
package brfb_pkg;

   localparam int LOG2_DEPTH = 8;
   localparam int DEPTH      = 1 << LOG2_DEPTH;
   localparam int ADDR_W     = LOG2_DEPTH;
   localparam int IDX_W      = LOG2_DEPTH + 1;
   localparam int MAX_BURST  = 64;
   localparam int LEN_W      = 7;
   localparam int CNT_W      = 9;
   localparam int SIZE_W     = 4;
   localparam int BYTE_W     = 8;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = 1;
   localparam int CMDQ_CNT_W = 2;
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 3;

   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_PEEK  = 3'd2;
   localparam logic [2:0] MODE_QUERY = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   typedef struct packed {
      logic              is_burst;
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic [CNT_W-1:0]  moved;
      logic [CNT_W-1:0]  occ;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] mask;
      logic [LEN_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              run_last;
      logic [CNT_W-1:0]  moved;
      logic [CNT_W-1:0]  occ;
   } rsp_word_type;

endpackage

/* src/brfb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module brfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/brfb_front.sv */
// Front end: accepts words, keeps the ring indices and issues commands to the back end.
module brfb_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [2:0]                      req_mode,
   input  logic [brfb_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                            req_burst_last,
   input  logic [brfb_pkg::LEN_W-1:0]      req_read_length,
   input  logic                            csr_write_en,
   input  logic [brfb_pkg::SIZE_W-1:0]     csr_write_data,
   input  logic                            cmdq_full,
   input  logic                            burst_done,
   output logic                            cmd_push,
   output brfb_pkg::cmd_type               cmd,
   output logic                            ram_wr_en,
   output logic [brfb_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [brfb_pkg::BYTE_W-1:0]     ram_wr_data
);

   logic [brfb_pkg::IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [brfb_pkg::IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [brfb_pkg::CNT_W-1:0]  burst_cnt_ff, burst_cnt_in;
   logic [brfb_pkg::BYTE_W-1:0] last_acc_ff, last_acc_in;
   logic [brfb_pkg::SIZE_W-1:0] size_ff, size_in;
   logic                        busy_ff, busy_in;

   logic [brfb_pkg::SIZE_W-1:0] size_c;
   logic [brfb_pkg::CNT_W-1:0]  cap;
   logic [brfb_pkg::ADDR_W-1:0] mask;
   logic [brfb_pkg::CNT_W-1:0]  occ;
   logic                        has_room;
   logic                        accept;
   logic [brfb_pkg::LEN_W-1:0]  len_c;
   logic [brfb_pkg::LEN_W-1:0]  n;
   logic [brfb_pkg::CNT_W-1:0]  burst_next;

   assign req_full = cmdq_full | busy_ff;
   assign accept   = req_push & ~req_full;

   always_comb begin
      if (size_ff < brfb_pkg::SIZE_W'(1)) begin
         size_c = brfb_pkg::SIZE_W'(1);
      end else if (size_ff > brfb_pkg::SIZE_W'(brfb_pkg::LOG2_DEPTH)) begin
         size_c = brfb_pkg::SIZE_W'(brfb_pkg::LOG2_DEPTH);
      end else begin
         size_c = size_ff;
      end
      cap      = brfb_pkg::CNT_W'(1) << size_c;
      mask     = brfb_pkg::ADDR_W'(cap - brfb_pkg::CNT_W'(1));
      occ      = brfb_pkg::CNT_W'(wr_idx_ff - rd_idx_ff);
      has_room = occ < cap;
      len_c    = (req_read_length > brfb_pkg::LEN_W'(brfb_pkg::MAX_BURST)) ?
                 brfb_pkg::LEN_W'(brfb_pkg::MAX_BURST) : req_read_length;
      n        = (brfb_pkg::CNT_W'(len_c) > occ) ? occ[brfb_pkg::LEN_W-1:0] : len_c;
      burst_next = (has_room && (burst_cnt_ff != '1)) ?
                   burst_cnt_ff + brfb_pkg::CNT_W'(1) : burst_cnt_ff;
   end

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      burst_cnt_in = burst_cnt_ff;
      last_acc_in  = last_acc_ff;
      size_in      = size_ff;
      busy_in      = busy_ff & ~burst_done;
      cmd_push     = 1'b0;
      cmd          = '0;
      cmd.occ      = occ;
      cmd.start    = rd_idx_ff[brfb_pkg::ADDR_W-1:0];
      cmd.mask     = mask;
      cmd.count    = n;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff[brfb_pkg::ADDR_W-1:0] & mask;
      ram_wr_data  = req_data_byte;
      if (csr_write_en) begin
         size_in      = csr_write_data;
         wr_idx_in    = '0;
         rd_idx_in    = '0;
         burst_cnt_in = '0;
      end else if (accept) begin
         case (req_mode)
            brfb_pkg::MODE_WRITE: begin
               if (has_room) begin
                  ram_wr_en   = 1'b1;
                  wr_idx_in   = wr_idx_ff + brfb_pkg::IDX_W'(1);
                  last_acc_in = req_data_byte;
               end
               burst_cnt_in = burst_next;
               if (req_burst_last) begin
                  cmd_push     = 1'b1;
                  cmd.moved    = burst_next;
                  cmd.occ      = occ + brfb_pkg::CNT_W'(has_room);
                  burst_cnt_in = '0;
               end
            end
            brfb_pkg::MODE_READ, brfb_pkg::MODE_PEEK: begin
               cmd_push = 1'b1;
               if (n != '0) begin
                  cmd.is_burst   = 1'b1;
                  cmd.byte_valid = 1'b1;
                  cmd.moved      = brfb_pkg::CNT_W'(n);
                  busy_in        = 1'b1;
                  if (req_mode == brfb_pkg::MODE_READ) begin
                     cmd.occ   = occ - brfb_pkg::CNT_W'(n);
                     rd_idx_in = rd_idx_ff + brfb_pkg::IDX_W'(n);
                  end
               end
            end
            brfb_pkg::MODE_QUERY: begin
               cmd_push       = 1'b1;
               cmd.out_byte   = last_acc_ff;
               cmd.byte_valid = 1'b1;
            end
            brfb_pkg::MODE_CLEAR: begin
               cmd_push     = 1'b1;
               cmd.occ      = '0;
               wr_idx_in    = '0;
               rd_idx_in    = '0;
               burst_cnt_in = '0;
            end
            default: begin
               cmd_push = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         burst_cnt_ff <= '0;
         last_acc_ff  <= '0;
         size_ff      <= brfb_pkg::SIZE_W'(brfb_pkg::LOG2_DEPTH);
         busy_ff      <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         burst_cnt_ff <= burst_cnt_in;
         last_acc_ff  <= last_acc_in;
         size_ff      <= size_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

/* src/brfb_cmdq.sv */
// Two-entry command queue between the front end and the back end.
module brfb_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brfb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output brfb_pkg::cmd_type head
);

   brfb_pkg::cmd_type                entry_ff [brfb_pkg::CMDQ_DEPTH];
   logic [brfb_pkg::CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [brfb_pkg::CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brfb_pkg::CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             do_push;
   logic                             do_pop;

   assign full    = cnt_ff == brfb_pkg::CMDQ_CNT_W'(brfb_pkg::CMDQ_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + brfb_pkg::CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + brfb_pkg::CMDQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + brfb_pkg::CMDQ_CNT_W'(do_push) - brfb_pkg::CMDQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* src/brfb_back.sv */
// Back end: walks burst commands through the byte store and queues result words.
module brfb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  brfb_pkg::cmd_type               cmd,
   output logic                            cmd_pop,
   output logic                            burst_done,
   output logic [brfb_pkg::ADDR_W-1:0]     ram_rd_addr,
   input  logic [brfb_pkg::BYTE_W-1:0]     ram_rd_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [brfb_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_run_last,
   output logic [brfb_pkg::CNT_W-1:0]      rsp_moved_count,
   output logic [brfb_pkg::CNT_W-1:0]      rsp_occupancy
);

   logic [brfb_pkg::LEN_W-1:0]      off_ff, off_in;
   logic                            s1_valid_ff;
   logic                            s1_use_ram_ff;
   brfb_pkg::rsp_word_type          s1_word_ff, s1_word_in;
   brfb_pkg::rsp_word_type          oq_ff [brfb_pkg::OUTQ_DEPTH];
   brfb_pkg::rsp_word_type          oq_word;
   brfb_pkg::rsp_word_type          head;
   logic [brfb_pkg::OUTQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [brfb_pkg::OUTQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [brfb_pkg::OUTQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;
   logic                            can_issue;
   logic                            issue;
   logic                            last_beat;
   logic                            oq_pop;

   assign can_issue = (brfb_pkg::OUTQ_CNT_W'(oq_cnt_ff) + brfb_pkg::OUTQ_CNT_W'(s1_valid_ff))
                      < brfb_pkg::OUTQ_CNT_W'(brfb_pkg::OUTQ_DEPTH);
   assign issue      = cmd_valid & can_issue;
   assign last_beat  = ~cmd.is_burst || ((off_ff + brfb_pkg::LEN_W'(1)) == cmd.count);
   assign cmd_pop    = issue & last_beat;
   assign burst_done = cmd_pop & cmd.is_burst;
   assign ram_rd_addr = (cmd.start + brfb_pkg::ADDR_W'(off_ff)) & cmd.mask;
   assign oq_pop     = rsp_pop & ~rsp_empty;

   always_comb begin
      off_in = off_ff;
      if (issue) begin
         off_in = last_beat ? '0 : off_ff + brfb_pkg::LEN_W'(1);
      end
      s1_word_in.out_byte   = cmd.out_byte;
      s1_word_in.byte_valid = cmd.byte_valid;
      s1_word_in.run_last   = last_beat;
      s1_word_in.moved      = cmd.moved;
      s1_word_in.occ        = cmd.occ;
      oq_word = s1_word_ff;
      if (s1_use_ram_ff) begin
         oq_word.out_byte = ram_rd_data;
      end
      oq_wr_in  = s1_valid_ff ? oq_wr_ff + brfb_pkg::OUTQ_PTR_W'(1) : oq_wr_ff;
      oq_rd_in  = oq_pop ? oq_rd_ff + brfb_pkg::OUTQ_PTR_W'(1) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + brfb_pkg::OUTQ_CNT_W'(s1_valid_ff)
                  - brfb_pkg::OUTQ_CNT_W'(oq_pop);
   end

   assign head            = oq_ff[oq_rd_ff];
   assign rsp_empty       = oq_cnt_ff == '0;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_byte_valid  = head.byte_valid;
   assign rsp_run_last    = head.run_last;
   assign rsp_moved_count = head.moved;
   assign rsp_occupancy   = head.occ;

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_word_ff    <= s1_word_in;
         s1_use_ram_ff <= cmd.is_burst;
      end
      if (s1_valid_ff) begin
         oq_ff[oq_wr_ff] <= oq_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= '0;
         s1_valid_ff <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         off_ff      <= off_in;
         s1_valid_ff <= issue;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

endmodule

/* src/byte_ring_fifo_burst_unit.sv */
// Top level of the byte ring FIFO with write bursts and read or peek bursts.
//
//   channel   handshake          direction   contents
//   req_      push / full        in          mode, data byte, burst end, read length
//   rsp_      empty / pop        out         byte, valid, run end, moved count, occupancy
//   csr_      write_en           in          size_log2 of the ring
//
// Writes, queries, clears and empty reads are accepted back to back while the command queue has room.
// A read or peek of n bytes reads them one at a time on the single store read port; new words wait
// until its last byte has been read. A result passes through the s1 register into the result queue.
// Reset clears indices and queues at once; the store itself is not cleared.
// The result queue holds four words; when it fills, the back end and then the input stall.
module byte_ring_fifo_burst_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [2:0]                      req_mode,
   input  logic [brfb_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                            req_burst_last,
   input  logic [brfb_pkg::LEN_W-1:0]      req_read_length,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [brfb_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_run_last,
   output logic [brfb_pkg::CNT_W-1:0]      rsp_moved_count,
   output logic [brfb_pkg::CNT_W-1:0]      rsp_occupancy,
   input  logic                            csr_write_en,
   input  logic [brfb_pkg::SIZE_W-1:0]     csr_write_data
);

   logic                        cmd_push;
   brfb_pkg::cmd_type           cmd_in;
   logic                        cmdq_full;
   logic                        cmdq_empty;
   brfb_pkg::cmd_type           cmd_head;
   logic                        cmd_pop;
   logic                        burst_done;
   logic                        ram_wr_en;
   logic [brfb_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [brfb_pkg::BYTE_W-1:0] ram_wr_data;
   logic [brfb_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [brfb_pkg::BYTE_W-1:0] ram_rd_data;

   brfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .req_burst_last  (req_burst_last),
      .req_read_length (req_read_length),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .cmdq_full       (cmdq_full),
      .burst_done      (burst_done),
      .cmd_push        (cmd_push),
      .cmd             (cmd_in),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data)
   );

   brfb_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (cmdq_full),
      .pop      (cmd_pop),
      .empty    (cmdq_empty),
      .head     (cmd_head)
   );

   brfb_ram #(
      .WIDTH (brfb_pkg::BYTE_W),
      .DEPTH (brfb_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   brfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (~cmdq_empty),
      .cmd             (cmd_head),
      .cmd_pop         (cmd_pop),
      .burst_done      (burst_done),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_moved_count (rsp_moved_count),
      .rsp_occupancy   (rsp_occupancy)
   );

   // The front end never pushes a command into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && cmdq_full))
      else $error("command pushed into a full queue");

   // No byte is stored while a burst command still has bytes to read.
   a_no_write_during_burst: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && !cmdq_empty && cmd_head.is_burst))
      else $error("store written while a burst is pending");

   // A burst only finishes when a burst command is at the head of the queue.
   a_done_from_burst: assert property (@(posedge clock) disable iff (reset)
      burst_done |-> (!cmdq_empty && cmd_head.is_burst))
      else $error("burst completion without a burst command");

   // The result queue is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result queue not empty after reset");

endmodule
